FILE: sv/fetpu_pkg.sv
// Shared types, constants and helper functions for the fp32 exp unit.
package fetpu_pkg;

  localparam int FMA_LAT = 8;
  localparam int FMA_N   = 10;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  localparam logic [31:0] F_MAGIC    = 32'h4B40_0000;
  localparam logic [31:0] F_MAGIC_N  = 32'hCB40_0000;
  localparam logic [31:0] F_ZERO_CUT = 32'hC2CF_F1B4;
  localparam logic [31:0] F_INF_CUT  = 32'h42B1_7217;
  localparam logic [31:0] F_LOG2E_X8 = 32'h4138_AA3B;
  localparam logic [31:0] F_NLN2_HI  = 32'hBDB1_7218;
  localparam logic [31:0] F_NLN2_LO  = 32'h2F82_E308;
  localparam logic [31:0] F_C2       = 32'h3F00_0445;
  localparam logic [31:0] F_C3       = 32'h3E2A_AD43;
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F_INF      = 32'h7F80_0000;
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic signed [31:0] EXP_LO = -32'sd1056964608;
  localparam logic signed [31:0] EXP_HI = 32'sd1065353216;

  typedef enum logic [1:0] {
    CLS_NUM,
    CLS_NAN,
    CLS_ZERO,
    CLS_INF
  } cls_t;

  typedef struct packed {
    logic [31:0] x;
    cls_t        cls;
  } q_entry_t;

  typedef struct packed {
    logic [31:0] x;
    cls_t        cls;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] tf;
    logic [31:0] n;
    logic [31:0] rx;
  } side_t;

  // Position of the highest set bit, by a six-step binary search.
  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [63:0] w;
    logic [5:0]  pos;
    w   = v;
    pos = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((w >> (1 << k)) != 64'd0) begin
        w   = w >> (1 << k);
        pos = pos | 6'(1 << k);
      end
    end
    return pos;
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] u);
    return u[31] ? ~u : (u | 32'h8000_0000);
  endfunction

  function automatic logic [31:0] pow2_eighths(input logic [2:0] k);
    logic [31:0] v;
    unique case (k)
      3'd0: v = 32'h3F80_0000;
      3'd1: v = 32'h3F8B_95C2;
      3'd2: v = 32'h3F98_37F0;
      3'd3: v = 32'h3FA5_FED7;
      3'd4: v = 32'h3FB5_04F3;
      3'd5: v = 32'h3FC5_672A;
      3'd6: v = 32'h3FD7_44FD;
      3'd7: v = 32'h3FEA_C0C7;
      default: v = 32'h3F80_0000;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/fetpu_fma.sv
// Eight-stage pipelined fp32 fused multiply-add, round to nearest even, subnormals kept.
module fetpu_fma import fetpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic        out_valid,
  output logic [31:0] y
);

  logic [FMA_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FMA_LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[FMA_LAT-1];

  // Stage 1: classify, unpack, multiply significands.
  logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, z_a, z_b, z_c, sp;
  logic        spec;
  logic [31:0] sval;
  logic [23:0] ma, mb, mc;
  logic signed [11:0] ea, eb, ec;

  always_comb begin
    nan_a = a[30:0] > F_INF[30:0];
    nan_b = b[30:0] > F_INF[30:0];
    nan_c = c[30:0] > F_INF[30:0];
    inf_a = a[30:0] == F_INF[30:0];
    inf_b = b[30:0] == F_INF[30:0];
    inf_c = c[30:0] == F_INF[30:0];
    z_a   = a[30:0] == 31'd0;
    z_b   = b[30:0] == 31'd0;
    z_c   = c[30:0] == 31'd0;
    sp    = a[31] ^ b[31];
    spec  = 1'b1;
    sval  = F_QNAN;
    priority if (nan_a || nan_b || nan_c) begin
      sval = F_QNAN;
    end else if (inf_a || inf_b) begin
      if (z_a || z_b) sval = F_QNAN;
      else if (inf_c && (c[31] != sp)) sval = F_QNAN;
      else sval = {sp, F_INF[30:0]};
    end else if (inf_c) begin
      sval = c;
    end else if (z_a || z_b) begin
      sval = z_c ? {sp & c[31], 31'd0} : c;
    end else begin
      spec = 1'b0;
    end
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    mc = {|c[30:23], c[22:0]};
    ea = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a[30:23]}) - 12'sd150;
    eb = (b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b[30:23]}) - 12'sd150;
    ec = (c[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, c[30:23]}) - 12'sd150;
  end

  logic [47:0]        p1_r;
  logic signed [11:0] ep1_r, ec1_r;
  logic [23:0]        mc1_r;
  logic               sp1_r, sc1_r, zc1_r, spec1_r;
  logic [31:0]        sval1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= ma * mb;
      ep1_r   <= ea + eb;
      mc1_r   <= mc;
      ec1_r   <= ec;
      sp1_r   <= sp;
      sc1_r   <= c[31];
      zc1_r   <= z_c;
      spec1_r <= spec;
      sval1_r <= sval;
    end
  end

  // Stage 2: leading-one positions of the product and the addend.
  logic [47:0]        p2_r;
  logic signed [11:0] ep2_r, ec2_r;
  logic [23:0]        mc2_r;
  logic [5:0]         msbp2_r, msbc2_r;
  logic               sp2_r, sc2_r, zc2_r, spec2_r;
  logic [31:0]        sval2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r    <= p1_r;
      ep2_r   <= ep1_r;
      mc2_r   <= mc1_r;
      ec2_r   <= ec1_r;
      msbp2_r <= msb64({16'd0, p1_r});
      msbc2_r <= msb64({40'd0, mc1_r});
      sp2_r   <= sp1_r;
      sc2_r   <= sc1_r;
      zc2_r   <= zc1_r;
      spec2_r <= spec1_r;
      sval2_r <= sval1_r;
    end
  end

  // Stage 3: pick the larger operand and work out both shift amounts.
  logic               pick_p;
  logic signed [11:0] kp, kc, ebig0, esml, ebig, dd;
  logic [63:0]        big0, sml0;
  logic [5:0]         msbb, sh;
  logic               sbig, ssml;

  always_comb begin
    kp     = ep2_r + $signed({6'd0, msbp2_r});
    kc     = ec2_r + $signed({6'd0, msbc2_r});
    pick_p = zc2_r || (kp >= kc);
    big0   = pick_p ? {16'd0, p2_r} : {40'd0, mc2_r};
    msbb   = pick_p ? msbp2_r : msbc2_r;
    ebig0  = pick_p ? ep2_r : ec2_r;
    sbig   = pick_p ? sp2_r : sc2_r;
    sml0   = zc2_r ? 64'd0 : (pick_p ? {40'd0, mc2_r} : {16'd0, p2_r});
    esml   = pick_p ? ec2_r : ep2_r;
    ssml   = pick_p ? sc2_r : sp2_r;
    sh     = 6'd61 - msbb;
    ebig   = ebig0 - $signed({6'd0, sh});
    dd     = esml - ebig;
  end

  logic [63:0]        big3_r, sml3_r;
  logic [5:0]         sh3_r;
  logic signed [11:0] ebig3_r, d3_r;
  logic               sbig3_r, ssml3_r, spec3_r;
  logic [31:0]        sval3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      big3_r  <= big0;
      sml3_r  <= sml0;
      sh3_r   <= sh;
      ebig3_r <= ebig;
      d3_r    <= dd;
      sbig3_r <= sbig;
      ssml3_r <= ssml;
      spec3_r <= spec2_r;
      sval3_r <= sval2_r;
    end
  end

  // Stage 4: normalize the larger operand to bit 61 and align the smaller one.
  logic [63:0]        sml_al;
  logic signed [11:0] nd;

  always_comb begin
    nd = -d3_r;
    if (d3_r >= 12'sd0) begin
      sml_al = sml3_r << d3_r[5:0];
    end else if (nd >= 12'sd64) begin
      sml_al = {63'd0, |sml3_r};
    end else begin
      sml_al = (sml3_r >> nd[5:0]) |
               {63'd0, |(sml3_r & ((64'd1 << nd[5:0]) - 64'd1))};
    end
  end

  logic [63:0]        big4_r, sml4_r;
  logic signed [11:0] ebig4_r;
  logic               sbig4_r, ssml4_r, spec4_r;
  logic [31:0]        sval4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      big4_r  <= big3_r << sh3_r;
      sml4_r  <= sml_al;
      ebig4_r <= ebig3_r;
      sbig4_r <= sbig3_r;
      ssml4_r <= ssml3_r;
      spec4_r <= spec3_r;
      sval4_r <= sval3_r;
    end
  end

  // Stage 5: signed-magnitude add.
  logic [63:0] sum;
  logic        sr;

  always_comb begin
    if (sbig4_r == ssml4_r) begin
      sum = big4_r + sml4_r;
      sr  = sbig4_r;
    end else if (big4_r >= sml4_r) begin
      sum = big4_r - sml4_r;
      sr  = sbig4_r;
    end else begin
      sum = sml4_r - big4_r;
      sr  = ssml4_r;
    end
  end

  logic [63:0]        r5_r;
  logic signed [11:0] e5_r;
  logic               sr5_r, spec5_r;
  logic [31:0]        sval5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r5_r    <= sum;
      e5_r    <= ebig4_r;
      sr5_r   <= sr;
      spec5_r <= spec4_r;
      sval5_r <= sval4_r;
    end
  end

  // Stage 6: rounding position, held back for subnormal results.
  logic signed [11:0] s0, lim, sft;

  always_comb begin
    s0  = $signed({6'd0, msb64(r5_r)}) - 12'sd23;
    lim = -12'sd149 - e5_r;
    sft = (s0 < lim) ? lim : s0;
  end

  logic [63:0]        r6_r;
  logic signed [11:0] s6_r, q6_r;
  logic               sr6_r, rz6_r, spec6_r;
  logic [31:0]        sval6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r6_r    <= r5_r;
      s6_r    <= sft;
      q6_r    <= e5_r + sft;
      sr6_r   <= sr5_r;
      rz6_r   <= (r5_r == 64'd0);
      spec6_r <= spec5_r;
      sval6_r <= sval5_r;
    end
  end

  // Stage 7: shift to 24 bits, guard and sticky.
  logic [23:0]        mpre;
  logic               up;
  logic [5:0]         amt;
  logic [63:0]        wsh;
  logic signed [11:0] ns;

  always_comb begin
    amt  = s6_r[5:0] - 6'd1;
    wsh  = r6_r >> amt;
    ns   = -s6_r;
    mpre = '0;
    up   = 1'b0;
    if (s6_r > 12'sd0) begin
      if (s6_r < 12'sd64) begin
        mpre = wsh[24:1];
        up   = wsh[0] && ((|(r6_r & ((64'd1 << amt) - 64'd1))) || wsh[1]);
      end
    end else begin
      mpre = r6_r[23:0] << ns[4:0];
    end
  end

  logic [23:0]        m7_r;
  logic               up7_r, sr7_r, rz7_r, spec7_r;
  logic signed [11:0] q7_r;
  logic [31:0]        sval7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m7_r    <= mpre;
      up7_r   <= up;
      q7_r    <= q6_r;
      sr7_r   <= sr6_r;
      rz7_r   <= rz6_r;
      spec7_r <= spec6_r;
      sval7_r <= sval6_r;
    end
  end

  // Stage 8: round up, renormalize, pack.
  logic [24:0]        mr;
  logic [23:0]        mn;
  logic signed [11:0] qq, eb8;
  logic [31:0]        packed_v, res;

  always_comb begin
    mr = {1'b0, m7_r} + {24'd0, up7_r};
    if (mr[24]) begin
      mn = mr[24:1];
      qq = q7_r + 12'sd1;
    end else begin
      mn = mr[23:0];
      qq = q7_r;
    end
    eb8      = qq + 12'sd149;
    packed_v = {eb8[8:0], 23'd0} + {8'd0, mn};
    priority if (spec7_r) begin
      res = sval7_r;
    end else if (rz7_r) begin
      res = 32'd0;
    end else if (mn == 24'd0) begin
      res = {sr7_r, 31'd0};
    end else if (mn[23] && (qq >= 12'sd105)) begin
      res = {sr7_r, F_INF[30:0]};
    end else begin
      res = {sr7_r, packed_v[30:0]};
    end
  end

  logic [31:0] y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= res;
    end
  end
  assign y = y_r;

endmodule

FILE: sv/fetpu_front.sv
// Front end: takes requests, sorts out the special ranges, hands them to the queue.
module fetpu_front import fetpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_bits,
  input  logic        q_full,
  output logic        push,
  output q_entry_t    push_entry
);

  logic        fvalid_r, fvalid_nxt;
  q_entry_t    fent_r;
  cls_t        cls;
  logic        load;

  always_comb begin
    if (in_x_bits[30:0] > F_INF[30:0]) begin
      cls = CLS_NAN;
    end else if (order_key(in_x_bits) < order_key(F_ZERO_CUT)) begin
      cls = CLS_ZERO;
    end else if (order_key(in_x_bits) > order_key(F_INF_CUT)) begin
      cls = CLS_INF;
    end else begin
      cls = CLS_NUM;
    end
  end

  assign in_stall   = fvalid_r && q_full;
  assign load       = in_valid && !in_stall;
  assign push       = fvalid_r && !q_full;
  assign push_entry = fent_r;

  always_comb begin
    if (load) fvalid_nxt = 1'b1;
    else if (push) fvalid_nxt = 1'b0;
    else fvalid_nxt = fvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= 1'b0;
    end else begin
      fvalid_r <= fvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fent_r.x   <= in_x_bits;
      fent_r.cls <= cls;
    end
  end

endmodule

FILE: sv/fetpu_queue.sv
// Short request queue between the front end and the arithmetic pipeline.
module fetpu_queue import fetpu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head,
  input  logic     pop
);

  q_entry_t       ent_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: sv/fetpu_back.sv
// Back end: ten chained FMA units evaluating the table and polynomial, plus the result register.
module fetpu_back import fetpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  q_entry_t    head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_y_bits
);

  logic        en;
  logic [31:0] fa [FMA_N];
  logic [31:0] fb [FMA_N];
  logic [31:0] fc [FMA_N];
  logic [31:0] fy [FMA_N];
  logic        fvi [FMA_N];
  logic        fvo [FMA_N];
  side_t       sin [FMA_N];
  side_t       sout [FMA_N];
  side_t       side_dl [FMA_N][FMA_LAT];

  logic [31:0]        e1u, e2;
  logic signed [31:0] e1s;
  logic [31:0]        fin;
  logic               out_valid_r;
  logic [31:0]        out_y_r;

  assign en  = !(out_valid_r && out_stall);
  assign pop = head_valid && en;

  always_comb begin
    // Exponent field of n/8, split into a clamped scale and a remainder scale.
    e1u = {fy[0][11:3], 23'd0};
    e1s = $signed(e1u);
    if (e1s < EXP_LO) e1s = EXP_LO;
    if (e1s > EXP_HI) e1s = EXP_HI;
    e2 = e1u - e1s;

    fvi[0] = pop;
    for (int j = 1; j < FMA_N; j++) fvi[j] = fvo[j-1];

    sin[0]     = '0;
    sin[0].x   = head.x;
    sin[0].cls = head.cls;
    fa[0] = head.x;     fb[0] = F_LOG2E_X8;  fc[0] = F_MAGIC;

    sin[1]    = sout[0];
    sin[1].s1 = e1s + F_ONE;
    sin[1].s2 = e2 + F_ONE;
    sin[1].tf = pow2_eighths(fy[0][2:0]);
    fa[1] = fy[0];      fb[1] = F_ONE;       fc[1] = F_MAGIC_N;

    sin[2]   = sout[1];
    sin[2].n = fy[1];
    fa[2] = fy[1];      fb[2] = F_NLN2_HI;   fc[2] = sout[1].x;

    sin[3] = sout[2];
    fa[3] = sout[2].n;  fb[3] = F_NLN2_LO;   fc[3] = fy[2];

    sin[4]    = sout[3];
    sin[4].rx = fy[3];
    fa[4] = fy[3];      fb[4] = F_C3;        fc[4] = F_C2;

    sin[5] = sout[4];
    fa[5] = sout[4].rx; fb[5] = fy[4];       fc[5] = F_NEG_ZERO;

    sin[6] = sout[5];
    fa[6] = sout[5].rx; fb[6] = fy[5];       fc[6] = sout[5].rx;

    sin[7] = sout[6];
    fa[7] = sout[6].tf; fb[7] = fy[6];       fc[7] = sout[6].tf;

    sin[8] = sout[7];
    fa[8] = sout[7].s1; fb[8] = fy[7];       fc[8] = F_NEG_ZERO;

    sin[9] = sout[8];
    fa[9] = sout[8].s2; fb[9] = fy[8];       fc[9] = F_NEG_ZERO;
  end

  for (genvar j = 0; j < FMA_N; j++) begin : g_fma
    fetpu_fma u_fma (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (fvi[j]),
      .a         (fa[j]),
      .b         (fb[j]),
      .c         (fc[j]),
      .out_valid (fvo[j]),
      .y         (fy[j])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        side_dl[j][0] <= sin[j];
        for (int k = 1; k < FMA_LAT; k++) side_dl[j][k] <= side_dl[j][k-1];
      end
    end
    assign sout[j] = side_dl[j][FMA_LAT-1];
  end

  always_comb begin
    unique case (sout[FMA_N-1].cls)
      CLS_NAN:  fin = sout[FMA_N-1].x;
      CLS_ZERO: fin = 32'd0;
      CLS_INF:  fin = F_INF;
      CLS_NUM:  fin = fy[FMA_N-1];
      default:  fin = fy[FMA_N-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fvo[FMA_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && fvo[FMA_N-1]) begin
      out_y_r <= fin;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_y_bits = out_y_r;

endmodule

FILE: sv/fp32_exp_table_poly_unit.sv
// Throughput: one request per cycle while the output is not stalled; a request passes through
// the front register, the queue, ten chained fused multiply-adds of eight pipeline stages each
// and the output register before its result appears on out_valid.
// A stalled output freezes the arithmetic pipeline; the four-entry queue keeps taking requests until it is full.
// Reset (synchronous, active low) empties the front register, the queue and all valid bits.
module fp32_exp_table_poly_unit import fetpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_y_bits
);

  logic     q_full, push, head_valid, pop;
  q_entry_t push_entry, head;

  fetpu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_x_bits  (in_x_bits),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  fetpu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  fetpu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_y_bits (out_y_bits)
  );

endmodule

FILE: sv/fetpu_chk.sv
// Port-level checker for the exp unit, bound to the top level.
module fetpu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_x_bits,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_y_bits
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_y_bits))
    else $error("stalled result changed");

  // A stalled request keeps its valid and its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_x_bits))
    else $error("stalled request changed");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind fp32_exp_table_poly_unit fetpu_chk u_fetpu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_x_bits  (in_x_bits),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_y_bits (out_y_bits)
);
